[rtl/rect_list_subtract_unit_macros.svh]
// assertion macros for the rectangle list subtract unit
`ifndef RECT_LIST_SUBTRACT_UNIT_MACROS_SVH
`define RECT_LIST_SUBTRACT_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define RLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rls_pkg.sv]
// shared types, codes and rectangle split logic
`timescale 1ns / 1ps

package rls_pkg;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
  } box_t;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    box_t       rect;
    logic [7:0] index;
  } cmd_t;

  typedef struct packed {
    logic [8:0] piece_count;
    logic [8:0] client_pieces;
    logic       overflow;
    logic       entry_valid;
    box_t       entry;
  } res_t;

  // per-axis coverage of an entry by the occluder
  localparam logic [1:0] MODE_ALL  = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;
  localparam logic [1:0] MODE_MID  = 2'd3;

  typedef struct packed {
    logic       overlap;
    logic       del;
    box_t       kept;
    box_t       p0;
    box_t       p1;
    box_t       p2;
    logic [1:0] n;
  } split_t;

  function automatic box_t mk(logic signed [15:0] l, logic signed [15:0] t,
                              logic signed [15:0] r, logic signed [15:0] b);
    box_t x;
    x.l = l;
    x.t = t;
    x.r = r;
    x.b = b;
    return x;
  endfunction

  function automatic logic [1:0] axis_mode(logic signed [15:0] olo, logic signed [15:0] rlo,
                                           logic signed [15:0] rhi, logic signed [15:0] ohi);
    logic [1:0] m;
    if (olo > rlo) begin
      m = (rhi > ohi) ? MODE_MID : MODE_HIGH;
    end else begin
      m = (rhi <= ohi) ? MODE_ALL : MODE_LOW;
    end
    return m;
  endfunction

  function automatic split_t split_box(box_t r, box_t o);
    split_t s;
    logic [1:0] xm;
    logic [1:0] ym;
    s.overlap = !((o.r <= r.l) || (r.r <= o.l) || (o.b <= r.t) || (r.b <= o.t));
    s.del  = 1'b0;
    s.kept = r;
    s.p0   = '0;
    s.p1   = '0;
    s.p2   = '0;
    s.n    = 2'd0;
    xm = axis_mode(o.l, r.l, r.r, o.r);
    ym = axis_mode(o.t, r.t, r.b, o.b);
    if (s.overlap) begin
      case ({xm, ym})
        {MODE_ALL, MODE_ALL}: begin
          s.del = 1'b1;
        end
        {MODE_ALL, MODE_LOW}: begin
          s.kept.t = o.b;
        end
        {MODE_ALL, MODE_HIGH}: begin
          s.kept.b = o.t;
        end
        {MODE_LOW, MODE_ALL}: begin
          s.kept.l = o.r;
        end
        {MODE_HIGH, MODE_ALL}: begin
          s.kept.r = o.l;
        end
        {MODE_ALL, MODE_MID}: begin
          s.p0 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd1;
          s.kept.b = o.t;
        end
        {MODE_MID, MODE_ALL}: begin
          s.p0 = mk(o.r, r.t, r.r, r.b);
          s.n = 2'd1;
          s.kept.r = o.l;
        end
        {MODE_LOW, MODE_LOW}: begin
          s.p0 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd1;
          s.kept.l = o.r;
          s.kept.b = o.b;
        end
        {MODE_HIGH, MODE_LOW}: begin
          s.p0 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd1;
          s.kept.r = o.l;
          s.kept.b = o.b;
        end
        {MODE_LOW, MODE_HIGH}: begin
          s.p0 = mk(o.r, o.t, r.r, r.b);
          s.n = 2'd1;
          s.kept.b = o.t;
        end
        {MODE_HIGH, MODE_HIGH}: begin
          s.p0 = mk(r.l, o.t, o.l, r.b);
          s.n = 2'd1;
          s.kept.b = o.t;
        end
        {MODE_LOW, MODE_MID}: begin
          s.p0 = mk(o.r, o.t, r.r, o.b);
          s.p1 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd2;
          s.kept.b = o.t;
        end
        {MODE_HIGH, MODE_MID}: begin
          s.p0 = mk(r.l, o.t, o.l, o.b);
          s.p1 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd2;
          s.kept.b = o.t;
        end
        {MODE_MID, MODE_LOW}: begin
          s.p0 = mk(o.r, r.t, r.r, o.b);
          s.p1 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd2;
          s.kept.r = o.l;
          s.kept.b = o.b;
        end
        {MODE_MID, MODE_HIGH}: begin
          s.p0 = mk(r.l, o.t, o.l, r.b);
          s.p1 = mk(o.r, o.t, r.r, r.b);
          s.n = 2'd2;
          s.kept.b = o.t;
        end
        default: begin
          s.p0 = mk(r.l, o.t, o.l, o.b);
          s.p1 = mk(o.r, o.t, r.r, o.b);
          s.p2 = mk(r.l, o.b, r.r, r.b);
          s.n = 2'd3;
          s.kept.b = o.t;
        end
      endcase
    end
    return s;
  endfunction

endpackage

[rtl/rect_list_subtract_unit.sv]
// top level of the rectangle list subtract unit
`timescale 1ns / 1ps

// Keeps an ordered list of up to LIST_DEPTH rectangles in one ram split in two halves;
// a subtract walks the current half from the last entry to the first and writes the
// surviving and new pieces into the other half, last first, through the single write
// port, which bounds the speed of a subtract. A new command is taken only once the
// last one is done and its result has been popped. Inputs queue in a two-deep
// command queue and one result is held until popped.

module rect_list_subtract_unit #(
  parameter int LIST_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind,
  input  logic signed [15:0] x_left,
  input  logic signed [15:0] y_top,
  input  logic signed [15:0] x_right,
  input  logic signed [15:0] y_bottom,
  input  logic [7:0]         entry_index,
  output logic               empty,
  input  logic               pop,
  output logic [8:0]         piece_count,
  output logic [8:0]         client_pieces,
  output logic               overflow,
  output logic               entry_valid,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_top,
  output logic signed [15:0] out_right,
  output logic signed [15:0] out_bottom
);
  import rls_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_valid;
  res_t res;

  rls_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .x_left      (x_left),
    .y_top       (y_top),
    .x_right     (x_right),
    .y_bottom    (y_bottom),
    .entry_index (entry_index),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  rls_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty         = !res_valid;
  assign piece_count   = res.piece_count;
  assign client_pieces = res.client_pieces;
  assign overflow      = res.overflow;
  assign entry_valid   = res.entry_valid;
  assign out_left      = res.entry.l;
  assign out_top       = res.entry.t;
  assign out_right     = res.entry.r;
  assign out_bottom    = res.entry.b;

endmodule

[rtl/rls_ram.sv]
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module rls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rls_front.sv]
// input side: accepts beats, decodes them and queues commands
`timescale 1ns / 1ps

module rls_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          kind,
  input  logic signed [15:0]  x_left,
  input  logic signed [15:0]  y_top,
  input  logic signed [15:0]  x_right,
  input  logic signed [15:0]  y_bottom,
  input  logic [7:0]          entry_index,
  output logic                cmd_valid,
  output rls_pkg::cmd_t       cmd,
  input  logic                cmd_pop
);
  import rls_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       incoming;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    incoming.kind   = kind_t'(kind);
    incoming.rect   = mk(x_left, y_top, x_right, y_bottom);
    incoming.index  = entry_index;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/rls_back.sv]
// execution side: list walk, split, copy between ram halves and result register
`timescale 1ns / 1ps

module rls_back #(
  parameter int LIST_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  rls_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_valid,
  output rls_pkg::res_t res,
  input  logic          res_pop
);
  import rls_pkg::*;

  localparam int IW  = $clog2(LIST_DEPTH);
  localparam int LW  = $clog2(LIST_DEPTH + 1);
  localparam int CLW = LW + 1;
  localparam int AW  = $clog2(2 * LIST_DEPTH);
  localparam int CW  = ((LW > 8) ? LW : 8) + 1;
  localparam int OW  = (LW > 9) ? LW : 9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_EVAL,
    S_WRITE,
    S_DONE
  } state_t;

  state_t        state;
  logic          bank;
  logic [LW-1:0] base;
  logic [LW-1:0] len;
  logic [LW-1:0] cb;
  box_t          occ;
  logic [IW-1:0] idx;
  logic          last;
  logic [LW-1:0] produced;
  logic [IW-1:0] wp;
  box_t          q1;
  box_t          q2;
  box_t          q3;
  logic [1:0]    rem;
  logic          ovf;

  logic          we;
  logic [AW-1:0] waddr;
  box_t          wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [63:0]   rdata;
  box_t          rbox;

  split_t        sp;
  logic [CLW-1:0] curlen;
  logic [CLW-1:0] room;
  logic [1:0]    fit;
  logic          deleted;
  logic [2:0]    nseq;
  box_t          lst [4];
  box_t          seq [4];
  logic [2:0]    kpos;
  logic [LW-1:0] cb_next;
  logic          rd_ok;
  logic [CW-1:0] rd_sum;

  function automatic logic [AW-1:0] ram_addr(logic bk, logic [IW-1:0] off);
    return bk ? (AW'(LIST_DEPTH) + AW'(off)) : AW'(off);
  endfunction

  function automatic logic [8:0] to9(logic [LW-1:0] v);
    logic [OW-1:0] w;
    w = OW'(v);
    return w[8:0];
  endfunction

  rls_ram #(
    .WIDTH (64),
    .DEPTH (2 * LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rbox    = box_t'(rdata);
  assign cmd_pop = (state == S_IDLE) && cmd_valid && !res_valid;
  assign rd_ok   = (CW'(cmd.index) < CW'(len));
  assign rd_sum  = CW'(base) + CW'(cmd.index);

  // split of the entry under the walk pointer and what it leaves behind
  always_comb begin
    sp      = split_box(rbox, occ);
    curlen  = CLW'(idx) + CLW'(1) + CLW'(produced);
    room    = CLW'(LIST_DEPTH) - curlen;
    fit     = (CLW'(sp.n) < room) ? sp.n : room[1:0];
    deleted = sp.overlap && sp.del;
    nseq    = deleted ? 3'd0 : ({1'b0, fit} + 3'd1);
    lst[0]  = sp.kept;
    lst[1]  = sp.p0;
    lst[2]  = sp.p1;
    lst[3]  = sp.p2;
    kpos    = 3'd0;
    for (int j = 0; j < 4; j++) begin
      kpos   = nseq - 3'd1 - 3'(j);
      seq[j] = lst[kpos[1:0]];
    end
    cb_next = cb;
    if (deleted && (CLW'(idx) < CLW'(cb))) begin
      cb_next = cb - LW'(1);
    end else if ((fit != 2'd0) && (CLW'(idx) + CLW'(1) <= CLW'(cb))) begin
      cb_next = cb + LW'(fit);
    end
  end

  // ram port steering
  always_comb begin
    we    = 1'b0;
    waddr = ram_addr(!bank, wp);
    wdata = q1;
    re    = 1'b0;
    raddr = ram_addr(bank, IW'(base + LW'(idx) - LW'(1)));
    case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          case (cmd.kind)
            KIND_LOAD: begin
              we    = 1'b1;
              waddr = ram_addr(bank, '0);
              wdata = cmd.rect;
            end
            KIND_SUB: begin
              re    = (len != '0);
              raddr = ram_addr(bank, IW'(base + len - LW'(1)));
            end
            KIND_READ: begin
              re    = rd_ok;
              raddr = ram_addr(bank, rd_sum[IW-1:0]);
            end
            default: begin
            end
          endcase
        end
      end
      S_EVAL: begin
        we    = (nseq != 3'd0);
        wdata = seq[0];
        re    = (idx != '0);
      end
      S_WRITE: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bank      <= 1'b0;
      base      <= '0;
      len       <= '0;
      cb        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            res.overflow    <= 1'b0;
            res.entry_valid <= 1'b0;
            res.entry       <= '0;
            case (cmd.kind)
              KIND_LOAD: begin
                base              <= '0;
                len               <= LW'(1);
                cb                <= LW'(1);
                res.piece_count   <= 9'd1;
                res.client_pieces <= 9'd1;
                res_valid         <= 1'b1;
              end
              KIND_SUB: begin
                res.piece_count   <= to9(len);
                res.client_pieces <= to9(cb);
                if (len == '0) begin
                  res_valid <= 1'b1;
                end else begin
                  occ      <= cmd.rect;
                  idx      <= IW'(len - LW'(1));
                  produced <= '0;
                  wp       <= IW'(LIST_DEPTH - 1);
                  ovf      <= 1'b0;
                  state    <= S_EVAL;
                end
              end
              KIND_READ: begin
                res.piece_count   <= to9(len);
                res.client_pieces <= to9(cb);
                if (rd_ok) begin
                  state <= S_RDATA;
                end else begin
                  res_valid <= 1'b1;
                end
              end
              default: begin
                res.piece_count   <= to9(len);
                res.client_pieces <= to9(cb);
                res_valid         <= 1'b1;
              end
            endcase
          end
        end
        S_RDATA: begin
          res.entry_valid <= 1'b1;
          res.entry       <= rbox;
          res_valid       <= 1'b1;
          state           <= S_IDLE;
        end
        S_EVAL: begin
          cb <= cb_next;
          if (fit < sp.n) begin
            ovf <= 1'b1;
          end
          if (nseq != 3'd0) begin
            produced <= produced + LW'(1);
            wp       <= wp - IW'(1);
          end
          q1   <= seq[1];
          q2   <= seq[2];
          q3   <= seq[3];
          rem  <= nseq[1:0] - 2'd1;
          last <= (idx == '0);
          idx  <= idx - IW'(1);
          if (nseq > 3'd1) begin
            state <= S_WRITE;
          end else if (idx == '0) begin
            state <= S_DONE;
          end
        end
        S_WRITE: begin
          produced <= produced + LW'(1);
          wp       <= wp - IW'(1);
          q1       <= q2;
          q2       <= q3;
          rem      <= rem - 2'd1;
          if (rem == 2'd1) begin
            state <= last ? S_DONE : S_EVAL;
          end
        end
        S_DONE: begin
          bank              <= !bank;
          len               <= produced;
          base              <= LW'(LIST_DEPTH) - produced;
          res.piece_count   <= to9(produced);
          res.client_pieces <= to9(cb);
          res.overflow      <= ovf;
          res_valid         <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/rls_checker.sv]
// port-level checks for the rectangle list subtract unit, with its bind
`timescale 1ns / 1ps
`include "rect_list_subtract_unit_macros.svh"

module rls_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [8:0]         piece_count,
  input logic [8:0]         client_pieces,
  input logic               entry_valid,
  input logic signed [15:0] out_left,
  input logic signed [15:0] out_top,
  input logic signed [15:0] out_right,
  input logic signed [15:0] out_bottom
);

  `RLS_ASSERT_NOW(a_client_le_count, !empty, client_pieces <= piece_count, "client count above list length")
  `RLS_ASSERT_NOW(a_edges_zero, !empty && !entry_valid, (out_left == 16'sd0) && (out_top == 16'sd0) && (out_right == 16'sd0) && (out_bottom == 16'sd0), "edges set without a valid entry")
  `RLS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(piece_count) && $stable(client_pieces), "waiting result beat changed")
  `RLS_ASSERT_NOW(a_reset_clean, $past(rst), empty && !full, "queues not empty after reset")

endmodule

bind rect_list_subtract_unit rls_checker u_rls_checker (.*);

[sim/tb_rect_list_subtract_unit.sv]
// testbench for the rectangle list subtract unit: directed table, random beats, then an overflow fill
`timescale 1ns / 1ps

module tb_rect_list_subtract_unit;
  import rls_pkg::*;

  localparam int DEPTH = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_BEATS = 990;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0] kind;
    box_t       rect;
    logic [7:0] index;
    logic       typed;
    res_t       res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] kind = 2'd0;
  logic signed [15:0] x_left = '0, y_top = '0, x_right = '0, y_bottom = '0;
  logic [7:0] entry_index = '0;
  logic [8:0] piece_count, client_pieces;
  logic overflow, entry_valid;
  logic signed [15:0] out_left, out_top, out_right, out_bottom;

  rect_list_subtract_unit uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  box_t vis_list[DEPTH];
  int unsigned vis_len;
  int unsigned client_cnt;
  res_t expected_q[$];
  int errors;
  int idle_cycles;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic box_t mkbox(int l, int t, int r, int b);
    box_t x;
    x.l = l[15:0];
    x.t = t[15:0];
    x.r = r[15:0];
    x.b = b[15:0];
    return x;
  endfunction

  function automatic void drop_piece(int unsigned i);
    if (vis_len == 0 || i >= vis_len) return;
    vis_len--;
    if (i < client_cnt) client_cnt--;
    for (int unsigned k = i; k < vis_len; k++) vis_list[k] = vis_list[k + 1];
  endfunction

  function automatic bit add_pieces(int unsigned pos, box_t p[3], int unsigned n);
    int unsigned room, fit;
    room = DEPTH - vis_len;
    fit = (n < room) ? n : room;
    if (fit > 0) begin
      for (int k = int'(vis_len) - 1; k >= int'(pos); k--) vis_list[k + fit] = vis_list[k];
      for (int unsigned k = 0; k < fit; k++) vis_list[pos + k] = p[k];
      vis_len += fit;
      if (pos <= client_cnt) client_cnt += fit;
    end
    return fit < n;
  endfunction

  function automatic bit occlude(box_t o);
    bit ovf;
    int unsigned idx, i, n;
    box_t r;
    box_t p[3];
    logic [1:0] xm, ym;
    ovf = 1'b0;
    idx = vis_len;
    while (idx > 0) begin
      i = idx - 1;
      idx = i;
      r = vis_list[i];
      n = 0;
      if (o.r <= r.l || r.r <= o.l || o.b <= r.t || r.b <= o.t) continue;
      if (o.l > r.l) xm = (r.r > o.r) ? MODE_MID : MODE_HIGH;
      else           xm = (r.r <= o.r) ? MODE_ALL : MODE_LOW;
      if (o.t > r.t) ym = (r.b > o.b) ? MODE_MID : MODE_HIGH;
      else           ym = (r.b <= o.b) ? MODE_ALL : MODE_LOW;
      case ({xm, ym})
        {MODE_ALL, MODE_ALL}: begin
          drop_piece(i);
          continue;
        end
        {MODE_ALL, MODE_LOW}: r.t = o.b;
        {MODE_ALL, MODE_HIGH}: r.b = o.t;
        {MODE_LOW, MODE_ALL}: r.l = o.r;
        {MODE_HIGH, MODE_ALL}: r.r = o.l;
        {MODE_ALL, MODE_MID}: begin
          p[0] = mkbox(r.l, o.b, r.r, r.b); n = 1; r.b = o.t;
        end
        {MODE_MID, MODE_ALL}: begin
          p[0] = mkbox(o.r, r.t, r.r, r.b); n = 1; r.r = o.l;
        end
        {MODE_LOW, MODE_LOW}: begin
          p[0] = mkbox(r.l, o.b, r.r, r.b); n = 1; r.l = o.r; r.b = o.b;
        end
        {MODE_HIGH, MODE_LOW}: begin
          p[0] = mkbox(r.l, o.b, r.r, r.b); n = 1; r.r = o.l; r.b = o.b;
        end
        {MODE_LOW, MODE_HIGH}: begin
          p[0] = mkbox(o.r, o.t, r.r, r.b); n = 1; r.b = o.t;
        end
        {MODE_HIGH, MODE_HIGH}: begin
          p[0] = mkbox(r.l, o.t, o.l, r.b); n = 1; r.b = o.t;
        end
        {MODE_LOW, MODE_MID}: begin
          p[0] = mkbox(o.r, o.t, r.r, o.b); p[1] = mkbox(r.l, o.b, r.r, r.b); n = 2;
          r.b = o.t;
        end
        {MODE_HIGH, MODE_MID}: begin
          p[0] = mkbox(r.l, o.t, o.l, o.b); p[1] = mkbox(r.l, o.b, r.r, r.b); n = 2;
          r.b = o.t;
        end
        {MODE_MID, MODE_LOW}: begin
          p[0] = mkbox(o.r, r.t, r.r, o.b); p[1] = mkbox(r.l, o.b, r.r, r.b); n = 2;
          r.r = o.l; r.b = o.b;
        end
        {MODE_MID, MODE_HIGH}: begin
          p[0] = mkbox(r.l, o.t, o.l, r.b); p[1] = mkbox(o.r, o.t, r.r, r.b); n = 2;
          r.b = o.t;
        end
        default: begin
          p[0] = mkbox(r.l, o.t, o.l, o.b); p[1] = mkbox(o.r, o.t, r.r, o.b);
          p[2] = mkbox(r.l, o.b, r.r, r.b); n = 3;
          r.b = o.t;
        end
      endcase
      vis_list[i] = r;
      if (n > 0 && add_pieces(i + 1, p, n)) ovf = 1'b1;
    end
    return ovf;
  endfunction

  function automatic res_t predict_visible(logic [1:0] k, box_t rc, logic [7:0] ei);
    res_t res;
    res = '0;
    if (k == KIND_LOAD) begin
      vis_list[0] = rc;
      vis_len = 1;
      client_cnt = 1;
    end else if (k == KIND_SUB) begin
      res.overflow = occlude(rc);
    end else if (k == KIND_READ && ei < vis_len) begin
      res.entry_valid = 1'b1;
      res.entry = vis_list[ei];
    end
    res.piece_count = vis_len[8:0];
    res.client_pieces = client_cnt[8:0];
    return res;
  endfunction

  // one beat into the block, prediction on acceptance
  task automatic send_beat(logic [1:0] k, box_t rc, logic [7:0] ei, bit typed, res_t want);
    res_t got;
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    x_left <= rc.l;
    y_top <= rc.t;
    x_right <= rc.r;
    y_bottom <= rc.b;
    entry_index <= ei;
    do @(posedge clk); while (full);
    got = predict_visible(k, rc, ei);
    if (typed && got !== want) report("directed row disagrees with predictor");
    expected_q.push_back(got);
  endtask

  function automatic box_t rand_box(int span);
    int l, t;
    l = $urandom_range(0, 2 * span) - span;
    t = $urandom_range(0, 2 * span) - span;
    return mkbox(l, t, l + $urandom_range(0, span), t + $urandom_range(0, span));
  endfunction

  function automatic box_t wild_box();
    return mkbox($urandom, $urandom, $urandom, $urandom);
  endfunction

  // result side
  initial begin
    res_t want;
    int gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_q.size() == 0) begin
        report("beat with no expectation");
      end else begin
        want = expected_q.pop_front();
        if (piece_count !== want.piece_count) report("piece_count mismatch");
        if (client_pieces !== want.client_pieces) report("client_pieces mismatch");
        if (overflow !== want.overflow) report("overflow mismatch");
        if (entry_valid !== want.entry_valid) report("entry_valid mismatch");
        if (out_left !== want.entry.l) report("out_left mismatch");
        if (out_top !== want.entry.t) report("out_top mismatch");
        if (out_right !== want.entry.r) report("out_right mismatch");
        if (out_bottom !== want.entry.b) report("out_bottom mismatch");
      end
    end
  end

  // watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    res_t z;
    box_t big;
    int fill;
    int ol[4];
    int orr[4];
    errors = 0;
    vis_len = 0;
    client_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    z = '0;
    big = mkbox(-32768, -32768, 32767, 32767);
    // after reset: empty list
    rw = '{KIND_READ, mkbox(0, 0, 0, 0), 8'd0, 1'b1, z}; rows.push_back(rw);
    rw = '{KIND_SUB, big, 8'd255, 1'b1, z}; rows.push_back(rw);
    z.piece_count = 9'd1; z.client_pieces = 9'd1;
    rw = '{KIND_LOAD, big, 8'd0, 1'b1, z}; rows.push_back(rw);
    z.entry_valid = 1'b1; z.entry = big;
    rw = '{KIND_READ, mkbox(-1, -1, -1, -1), 8'd0, 1'b1, z}; rows.push_back(rw);
    z.entry_valid = 1'b0; z.entry = '0;
    rw = '{KIND_READ, '0, 8'd255, 1'b1, z}; rows.push_back(rw);
    rw = '{KIND_SPARE, big, 8'd0, 1'b1, z}; rows.push_back(rw);
    // centre hole: four pieces
    rw = '{KIND_SUB, mkbox(-100, -100, 100, 100), 8'd0, 1'b0, z}; rows.push_back(rw);
    for (int i = 0; i < 5; i++) begin
      rw = '{KIND_READ, '0, 8'(i), 1'b0, z}; rows.push_back(rw);
    end
    // each axis mode combination against a 0..100 square
    ol = '{-10, -10, 50, 30};
    orr = '{110, 50, 110, 60};
    for (int xm = 0; xm < 4; xm++)
      for (int ym = 0; ym < 4; ym++) begin
        rw = '{KIND_LOAD, mkbox(0, 0, 100, 100), 8'd0, 1'b0, z}; rows.push_back(rw);
        rw = '{KIND_SUB, mkbox(ol[xm], ol[ym], orr[xm], orr[ym]), 8'd0, 1'b0, z};
        if (xm == 0 && ym == 0) begin
          z.piece_count = 9'd0; z.client_pieces = 9'd0;
          rw.typed = 1'b1; rw.res = z;
        end
        rows.push_back(rw);
      end
    // inverted rectangle load and no-overlap subtract
    rw = '{KIND_LOAD, mkbox(50, 50, -50, -50), 8'd0, 1'b0, z}; rows.push_back(rw);
    rw = '{KIND_SUB, mkbox(-10, -10, 10, 10), 8'd0, 1'b0, z}; rows.push_back(rw);
    rw = '{KIND_READ, '0, 8'd0, 1'b0, z}; rows.push_back(rw);

    foreach (rows[i]) send_beat(rows[i].kind, rows[i].rect, rows[i].index,
                                rows[i].typed, rows[i].res);

    // random: mostly subtracts and reads, some on a small grid, with occasional loads and spare-kind beats
    fill = 0;
    while (fill < RANDOM_BEATS) begin
      int pick;
      box_t rc;
      pick = $urandom_range(0, 99);
      if (pick < 4) rc = wild_box();
      else rc = rand_box(pick < 50 ? 64 : 2000);
      if (vis_len == 0 || pick < 6)
        send_beat(KIND_LOAD, (pick < 3) ? wild_box() : rand_box(512), 8'($urandom), 0, z);
      else if (pick < 60)
        send_beat(KIND_SUB, rc, 8'($urandom), 0, z);
      else if (pick < 95)
        send_beat(KIND_READ, wild_box(),
                  (pick < 90) ? 8'($urandom_range(0, vis_len)) : 8'($urandom), 0, z);
      else
        send_beat(KIND_SPARE, wild_box(), 8'($urandom), 0, z);
      fill++;
    end
    // fill towards overflow with many small occluders on a big load
    send_beat(KIND_LOAD, mkbox(0, 0, 4000, 4000), 8'd0, 0, z);
    for (int i = 0; i < 120 && expected_q.size() < 1000; i++)
      send_beat(KIND_SUB, mkbox(40 + 30 * (i % 100), 40 + 30 * (i / 10), 50 + 30 * (i % 100),
                                50 + 30 * (i / 10)), 8'd0, 0, z);
    for (int i = 0; i < 10; i++) send_beat(KIND_READ, '0, 8'($urandom), 0, z);
    push <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
